// ===== rtl/core/mrsc_pkg.sv =====
// Shared types, widths, register indexes and constants of the motor
// reversal speed controller. No dependencies; every other file of the
// block refers to it by scoped names.
package mrsc_pkg;

   // Field widths.
   localparam int SAMPLE_W    = 12;
   localparam int PAUSE_W     = 10;
   localparam int LOCKOUT_W   = 8;
   localparam int REFRESH_W   = 10;
   localparam int PERCENT_W   = 7;
   localparam int SEGMENT_W   = 7;
   localparam int DIGIT_COUNT = 3;
   localparam int DIGIT_SEL_W = $clog2(DIGIT_COUNT);
   localparam int BCD_W       = 4;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAUSE_TICKS   = 2'd0,
      CSR_LOCKOUT_TICKS = 2'd1,
      CSR_REFRESH_TICKS = 2'd2
   } csr_index_type;

   localparam logic [PAUSE_W-1:0]   PAUSE_TICKS_RESET   = 10'd500;
   localparam logic [LOCKOUT_W-1:0] LOCKOUT_TICKS_RESET = 8'd200;
   localparam logic [REFRESH_W-1:0] REFRESH_TICKS_RESET = 10'd300;

   // Display constants.
   localparam int SAMPLE_MAX   = 4095;
   localparam int PERCENT_FULL = 100;
   localparam logic [REFRESH_W-1:0] REFRESH_SAT = REFRESH_W'((2 ** REFRESH_W) - 1);
   localparam logic [DIGIT_SEL_W-1:0] DIGIT_LAST = DIGIT_SEL_W'(DIGIT_COUNT - 1);

   // Percent = 100 * sample / SAMPLE_MAX, done as a multiply by a rounded-up
   // reciprocal. The shift is large enough that the quotient is exact for
   // every numerator up to 100 times the largest sample.
   localparam longint PCT_NUM_MAX = longint'(PERCENT_FULL) * ((longint'(1) << SAMPLE_W) - 1);
   localparam int     PCT_NUM_W   = $clog2(PCT_NUM_MAX + 1);
   localparam int     PCT_SHIFT   = $clog2(PCT_NUM_MAX * longint'(SAMPLE_MAX)) + 1;
   localparam longint PCT_RECIP   =
      ((longint'(1) << PCT_SHIFT) + longint'(SAMPLE_MAX) - 1) / longint'(SAMPLE_MAX);
   localparam int     PCT_RECIP_W = $clog2(PCT_RECIP + 1);
   localparam int     PCT_PROD_W  = PCT_NUM_W + PCT_RECIP_W;
   localparam int     PCT_Q_W     = PCT_PROD_W - PCT_SHIFT;

   // Division by ten of a percent value: (p * 205) >> 11 is exact below 1029.
   localparam int DIV10_MUL   = 205;
   localparam int DIV10_SHIFT = 11;
   localparam int DIV10_W     = PERCENT_W + 8;

   typedef struct packed {
      logic [PAUSE_W-1:0]   pause_ticks;
      logic [LOCKOUT_W-1:0] lockout_ticks;
      logic [REFRESH_W-1:0] refresh_ticks;
   } cfg_type;

   // Per-word control from the motor section to the display section.
   typedef struct packed {
      logic step;
      logic normal;
   } tick_ctrl_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] duty;
      logic                direction;
      logic                green_led;
      logic                red_led;
      logic                running;
   } motor_out_type;

   // Segment patterns, bit0 is segment a.
   function automatic logic [SEGMENT_W-1:0] seg_pattern(input logic [BCD_W-1:0] digit);
      logic [SEGMENT_W-1:0] pattern;
      case (digit)
         4'd0:    pattern = 7'h3F;
         4'd1:    pattern = 7'h06;
         4'd2:    pattern = 7'h5B;
         4'd3:    pattern = 7'h4F;
         4'd4:    pattern = 7'h66;
         4'd5:    pattern = 7'h6D;
         4'd6:    pattern = 7'h7D;
         4'd7:    pattern = 7'h07;
         4'd8:    pattern = 7'h7F;
         4'd9:    pattern = 7'h6F;
         default: pattern = 7'h00;
      endcase
      return pattern;
   endfunction

endpackage

// ===== rtl/core/mrsc_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on mrsc_pkg for the field widths.
interface mrsc_req_if;
   logic                          valid;
   logic                          ready;
   logic [mrsc_pkg::SAMPLE_W-1:0] speed_sample;
   logic                          cw_button_level;
   logic                          ccw_button_level;

   modport source(output valid, speed_sample, cw_button_level, ccw_button_level,
                  input ready);
   modport sink(input valid, speed_sample, cw_button_level, ccw_button_level,
                output ready);
endinterface

interface mrsc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mrsc_pkg::SAMPLE_W-1:0]    pwm_duty;
   logic                             direction;
   logic                             green_led;
   logic                             red_led;
   logic [mrsc_pkg::SEGMENT_W-1:0]   segments;
   logic [mrsc_pkg::DIGIT_COUNT-1:0] digit_enable;
   logic                             motor_running;

   modport source(output valid, pwm_duty, direction, green_led, red_led, segments,
                  digit_enable, motor_running, input ready);
   modport sink(input valid, pwm_duty, direction, green_led, red_led, segments,
                digit_enable, motor_running, output ready);
endinterface

// ===== rtl/core/mrsc_motor.sv =====
// Motor section: stage, lockout, pause and held outputs, updated once per word.
// Depends on mrsc_pkg.
module mrsc_motor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [mrsc_pkg::SAMPLE_W-1:0] sample,
   input  logic                          cw_level,
   input  logic                          ccw_level,
   input  mrsc_pkg::cfg_type             cfg,
   output mrsc_pkg::motor_out_type       result,
   output mrsc_pkg::tick_ctrl_type       tick_ctrl
);

   logic                           stage_ff, stage_in;
   logic                           reversal_done_ff, reversal_done_in;
   logic                           pause_active_ff, pause_active_in;
   logic [mrsc_pkg::PAUSE_W-1:0]   pause_count_ff, pause_count_in;
   logic [mrsc_pkg::LOCKOUT_W-1:0] lockout_count_ff, lockout_count_in;
   logic                           last_cw_ff, last_cw_in;
   logic                           last_ccw_ff, last_ccw_in;
   logic [mrsc_pkg::SAMPLE_W-1:0]  held_duty_ff, held_duty_in;
   logic                           held_direction_ff, held_direction_in;
   logic [mrsc_pkg::SAMPLE_W-1:0]  last_sample_ff, last_sample_in;

   logic running;
   logic in_lockout;
   logic in_pause;
   logic pause_start;
   logic led_stage;
   logic watched_level;
   logic watched_last;

   assign running     = (last_sample_ff != '0);
   assign in_lockout  = (lockout_count_ff != '0);
   assign in_pause    = pause_active_ff && (pause_count_ff != '0);
   assign pause_start = !pause_active_ff && running && !reversal_done_ff;

   // In stage 0 only the counter-clockwise button is watched, and vice versa.
   assign watched_level = stage_ff ? cw_level : ccw_level;
   assign watched_last  = stage_ff ? last_cw_ff : last_ccw_ff;

   always_comb begin
      stage_in          = stage_ff;
      reversal_done_in  = reversal_done_ff;
      pause_active_in   = pause_active_ff;
      pause_count_in    = pause_count_ff;
      lockout_count_in  = lockout_count_ff;
      last_cw_in        = last_cw_ff;
      last_ccw_in       = last_ccw_ff;
      held_duty_in      = held_duty_ff;
      held_direction_in = held_direction_ff;
      last_sample_in    = last_sample_ff;
      led_stage         = stage_ff;
      result.duty       = held_duty_ff;
      result.direction  = held_direction_ff;
      tick_ctrl.normal  = 1'b0;

      if (in_lockout) begin
         // Outputs freeze; the LEDs still show the stage before the switch.
         lockout_count_in = lockout_count_ff - 1'b1;
         led_stage        = ~stage_ff;
      end else if (in_pause) begin
         pause_count_in = pause_count_ff - 1'b1;
         result.duty    = '0;
         held_duty_in   = '0;
      end else if (pause_start) begin
         // This word is the first zero-duty word of the pause.
         pause_active_in = 1'b1;
         pause_count_in  = (cfg.pause_ticks == '0) ? '0 : cfg.pause_ticks - 1'b1;
         result.duty     = '0;
         held_duty_in    = '0;
      end else begin
         tick_ctrl.normal = 1'b1;
         if (pause_active_ff) begin
            pause_active_in  = 1'b0;
            reversal_done_in = 1'b1;
         end
         result.direction  = stage_ff;
         result.duty       = sample;
         last_sample_in    = sample;
         held_duty_in      = sample;
         held_direction_in = stage_ff;
         if (stage_ff) begin
            last_cw_in = watched_level;
         end else begin
            last_ccw_in = watched_level;
         end
         if (watched_last && !watched_level) begin
            stage_in         = ~stage_ff;
            reversal_done_in = 1'b0;
            lockout_count_in = cfg.lockout_ticks;
         end
      end

      result.green_led = ~led_stage;
      result.red_led   = led_stage;
      result.running   = running;
      tick_ctrl.step   = step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff          <= 1'b0;
         reversal_done_ff  <= 1'b0;
         pause_active_ff   <= 1'b0;
         pause_count_ff    <= '0;
         lockout_count_ff  <= '0;
         last_cw_ff        <= 1'b1;
         last_ccw_ff       <= 1'b1;
         held_duty_ff      <= '0;
         held_direction_ff <= 1'b0;
         last_sample_ff    <= '0;
      end else if (step) begin
         stage_ff          <= stage_in;
         reversal_done_ff  <= reversal_done_in;
         pause_active_ff   <= pause_active_in;
         pause_count_ff    <= pause_count_in;
         lockout_count_ff  <= lockout_count_in;
         last_cw_ff        <= last_cw_in;
         last_ccw_ff       <= last_ccw_in;
         held_duty_ff      <= held_duty_in;
         held_direction_ff <= held_direction_in;
         last_sample_ff    <= last_sample_in;
      end
   end

endmodule

// ===== rtl/core/mrsc_display.sv =====
// Display section: refresh counter, shown percent and digit multiplexing.
// Depends on mrsc_pkg.
module mrsc_display (
   input  logic                             clock,
   input  logic                             reset,
   input  mrsc_pkg::tick_ctrl_type          tick_ctrl,
   input  logic [mrsc_pkg::SAMPLE_W-1:0]    sample,
   input  logic [mrsc_pkg::REFRESH_W-1:0]   refresh_ticks,
   output logic [mrsc_pkg::SEGMENT_W-1:0]   segments,
   output logic [mrsc_pkg::DIGIT_COUNT-1:0] digit_enable
);

   logic [mrsc_pkg::REFRESH_W-1:0]   refresh_count_ff, refresh_count_in;
   logic [mrsc_pkg::PERCENT_W-1:0]   shown_percent_ff, shown_percent_in;
   logic [mrsc_pkg::DIGIT_SEL_W-1:0] digit_select_ff, digit_select_in;

   logic [mrsc_pkg::REFRESH_W-1:0]  refresh_inc;
   logic                            refresh_due;
   logic [mrsc_pkg::PCT_NUM_W-1:0]  pct_num;
   logic [mrsc_pkg::PCT_PROD_W-1:0] pct_prod;
   logic [mrsc_pkg::PCT_Q_W-1:0]    pct_quot;
   logic [mrsc_pkg::PERCENT_W-1:0]  pct_sat;
   logic [mrsc_pkg::DIV10_W-1:0]    div10_prod;
   logic [mrsc_pkg::BCD_W-1:0]      tens_raw;
   logic [mrsc_pkg::BCD_W-1:0]      digit_hundreds;
   logic [mrsc_pkg::BCD_W-1:0]      digit_tens;
   logic [mrsc_pkg::BCD_W-1:0]      digit_units;
   logic [mrsc_pkg::BCD_W-1:0]      digit_value;
   logic [mrsc_pkg::PERCENT_W-1:0]  tens_times_ten;

   // The counter advances before the display section compares it with refresh_ticks.
   assign refresh_inc = (refresh_count_ff == mrsc_pkg::REFRESH_SAT) ?
                        refresh_count_ff : refresh_count_ff + 1'b1;
   assign refresh_due = (refresh_inc >= refresh_ticks);

   // 100 * sample as shifts and adds, then the reciprocal multiply.
   assign pct_num  = (mrsc_pkg::PCT_NUM_W'(sample) << 6) +
                     (mrsc_pkg::PCT_NUM_W'(sample) << 5) +
                     (mrsc_pkg::PCT_NUM_W'(sample) << 2);
   assign pct_prod = mrsc_pkg::PCT_PROD_W'(pct_num) *
                     mrsc_pkg::PCT_PROD_W'(mrsc_pkg::PCT_RECIP);
   assign pct_quot = pct_prod[mrsc_pkg::PCT_PROD_W-1:mrsc_pkg::PCT_SHIFT];
   assign pct_sat  = (pct_quot > mrsc_pkg::PCT_Q_W'(mrsc_pkg::PERCENT_FULL)) ?
                     mrsc_pkg::PERCENT_W'(mrsc_pkg::PERCENT_FULL) :
                     pct_quot[mrsc_pkg::PERCENT_W-1:0];

   always_comb begin
      refresh_count_in = refresh_inc;
      shown_percent_in = shown_percent_ff;
      if (tick_ctrl.normal && refresh_due) begin
         refresh_count_in = '0;
         shown_percent_in = pct_sat;
      end
      digit_select_in = (digit_select_ff >= mrsc_pkg::DIGIT_LAST) ?
                        '0 : digit_select_ff + 1'b1;
   end

   // Decimal digits of the shown percent, which never exceeds 100.
   assign div10_prod     = mrsc_pkg::DIV10_W'(shown_percent_ff) *
                           mrsc_pkg::DIV10_W'(mrsc_pkg::DIV10_MUL);
   assign tens_raw       = mrsc_pkg::BCD_W'(div10_prod >> mrsc_pkg::DIV10_SHIFT);
   assign tens_times_ten = (mrsc_pkg::PERCENT_W'(tens_raw) << 3) +
                           (mrsc_pkg::PERCENT_W'(tens_raw) << 1);
   assign digit_units    = mrsc_pkg::BCD_W'(shown_percent_ff - tens_times_ten);
   assign digit_tens     = (tens_raw >= 4'd10) ? tens_raw - 4'd10 : tens_raw;
   assign digit_hundreds = (shown_percent_ff >= mrsc_pkg::PERCENT_W'(mrsc_pkg::PERCENT_FULL)) ?
                           4'd1 : 4'd0;

   always_comb begin
      case (digit_select_ff)
         2'd0:    digit_value = digit_hundreds;
         2'd1:    digit_value = digit_tens;
         default: digit_value = digit_units;
      endcase
   end

   assign segments     = mrsc_pkg::seg_pattern(digit_value);
   assign digit_enable = mrsc_pkg::DIGIT_COUNT'(1) << digit_select_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_count_ff <= '0;
         shown_percent_ff <= '0;
         digit_select_ff  <= '0;
      end else if (tick_ctrl.step) begin
         refresh_count_ff <= refresh_count_in;
         shown_percent_ff <= shown_percent_in;
         digit_select_ff  <= digit_select_in;
      end
   end

endmodule

// ===== rtl/core/motor_reversal_speed_controller.sv =====
// Motor reversal speed controller, one word per millisecond tick.
// An accepted request word is held in the input register, then passes through the
// motor and display logic into the response register. Throughput: one word per
// cycle while the response is not stalled. A stalled response
// holds the input register, so only one more word is taken in until it drains.
// Synchronous active-high reset clears all control state and loads register defaults.
module motor_reversal_speed_controller (
   input  logic                            clock,
   input  logic                            reset,
   mrsc_req_if.sink                        req_chan,
   mrsc_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [mrsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mrsc_pkg::CSR_DATA_W-1:0]  csr_data
);

   mrsc_pkg::cfg_type cfg_ff;

   logic                          s1_valid_ff, s1_valid_in;
   logic [mrsc_pkg::SAMPLE_W-1:0] s1_sample_ff;
   logic                          s1_cw_ff;
   logic                          s1_ccw_ff;

   logic                             out_valid_ff, out_valid_in;
   mrsc_pkg::motor_out_type          out_motor_ff;
   logic [mrsc_pkg::SEGMENT_W-1:0]   out_segments_ff;
   logic [mrsc_pkg::DIGIT_COUNT-1:0] out_digit_enable_ff;

   logic                             s1_load;
   logic                             out_load;
   mrsc_pkg::motor_out_type          motor_result;
   mrsc_pkg::tick_ctrl_type          tick_ctrl;
   logic [mrsc_pkg::SEGMENT_W-1:0]   segments;
   logic [mrsc_pkg::DIGIT_COUNT-1:0] digit_enable;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pause_ticks   <= mrsc_pkg::PAUSE_TICKS_RESET;
         cfg_ff.lockout_ticks <= mrsc_pkg::LOCKOUT_TICKS_RESET;
         cfg_ff.refresh_ticks <= mrsc_pkg::REFRESH_TICKS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            mrsc_pkg::CSR_PAUSE_TICKS: begin
               cfg_ff.pause_ticks <= csr_data[mrsc_pkg::PAUSE_W-1:0];
            end
            mrsc_pkg::CSR_LOCKOUT_TICKS: begin
               cfg_ff.lockout_ticks <= csr_data[mrsc_pkg::LOCKOUT_W-1:0];
            end
            mrsc_pkg::CSR_REFRESH_TICKS: begin
               cfg_ff.refresh_ticks <= csr_data[mrsc_pkg::REFRESH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The state advances when a word moves from the input register into the
   // response register.
   assign out_load       = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || out_load;
   assign s1_load        = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_sample_ff <= req_chan.speed_sample;
         s1_cw_ff     <= req_chan.cw_button_level;
         s1_ccw_ff    <= req_chan.ccw_button_level;
      end
      if (out_load) begin
         out_motor_ff        <= motor_result;
         out_segments_ff     <= segments;
         out_digit_enable_ff <= digit_enable;
      end
   end

   mrsc_motor u_motor (
      .clock     (clock),
      .reset     (reset),
      .step      (out_load),
      .sample    (s1_sample_ff),
      .cw_level  (s1_cw_ff),
      .ccw_level (s1_ccw_ff),
      .cfg       (cfg_ff),
      .result    (motor_result),
      .tick_ctrl (tick_ctrl)
   );

   mrsc_display u_display (
      .clock         (clock),
      .reset         (reset),
      .tick_ctrl     (tick_ctrl),
      .sample        (s1_sample_ff),
      .refresh_ticks (cfg_ff.refresh_ticks),
      .segments      (segments),
      .digit_enable  (digit_enable)
   );

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.pwm_duty      = out_motor_ff.duty;
   assign rsp_chan.direction     = out_motor_ff.direction;
   assign rsp_chan.green_led     = out_motor_ff.green_led;
   assign rsp_chan.red_led       = out_motor_ff.red_led;
   assign rsp_chan.segments      = out_segments_ff;
   assign rsp_chan.digit_enable  = out_digit_enable_ff;
   assign rsp_chan.motor_running = out_motor_ff.running;

endmodule
